// File: sv/hwfc_pkg.sv
// Shared types, constants and helpers for the heightmap false-color pipeline.
// No dependencies; imported by every module of the block.
package hwfc_pkg;

    localparam int SRC_W      = 16;   // Q8.8 input and register width
    localparam int MAG_W      = 17;   // magnitude of a height difference or 3*depth
    localparam int DIV_STEPS  = 4;    // quotient bits resolved per divider stage
    localparam int WATER_BIAS = 256;  // 1.0 in Q8.8, added to 3*|depth|
    localparam logic [7:0] ALPHA = 8'hFF;

    typedef enum logic [0:0] {
        REG_MIN_HEIGHT = 1'b0,
        REG_MAX_HEIGHT = 1'b1
    } hwfc_reg_t;

    // Signs and range flag that travel beside the three divisions.
    typedef struct packed {
        logic t_ok;
        logic t_neg;
        logic w_neg;
        logic s_neg;
    } hwfc_sign_t;

    // |3*d| for a Q8.8 depth, built as d + 2d.
    function automatic logic [MAG_W-1:0] depth_mag(input logic [SRC_W-1:0] d);
        logic [SRC_W+1:0] x3;
        logic [SRC_W+1:0] m;
        x3 = {{2{d[SRC_W-1]}}, d} + {d[SRC_W-1], d, 1'b0};
        m  = x3[SRC_W+1] ? (~x3 + 1'b1) : x3;
        return m[MAG_W-1:0];
    endfunction

endpackage

// File: sv/heightmap_water_false_color.sv
// Top level of the heightmap false-color block: config registers, flow control, datapath.
// Depends on hwfc_pkg, hwfc_div_pipe and hwfc_blend.
//
// One map item (terrain height, water depth, sediment depth, all signed Q8.8) in,
// one RGBA word out. The height is scaled to (h - min) / (max - min) with FRAC_BITS
// fraction bits (zero when max <= min, no clamp), the grey is pulled toward blue by
// the water weight 3w/(1+3|w|) and toward cyan by the same weight of sediment, then
// each channel is clamped to 0..1, scaled by 255 and floored; alpha is always 255.
// Throughput is one item per clock while the output is not stalled. The three long
// dividers (height ratio and two weights, run side by side) span DIV_STAGES =
// ceil((FRAC_BITS + 17) / 4) stages and resolve four quotient bits per stage. Each
// stage has its own valid bit and a stage loads whenever it is empty or its item moves
// on, so bubbles are squeezed out and s_ready stays high while any stage is free, also
// while m_valid waits on m_ready.
// min_height and max_height are written through cfg_wr_en / cfg_index / cfg_data and
// should only change while no item is in flight.
module heightmap_water_false_color
    import hwfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_terrain_height,
    input  logic [15:0] s_water_depth,
    input  logic [15:0] s_sediment_depth,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_rgba_word
);

    localparam int QW         = FRAC_BITS + MAG_W;
    localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int VW         = FRAC_BITS + 22;   // internal signed value width
    localparam int WW         = FRAC_BITS + 1;    // signed weight width

    // Stage map: input register, divider, sign fix-up, blend 1 (2), blend 2 (2), output.
    localparam int ST_IN   = 0;
    localparam int ST_DIV0 = 1;
    localparam int ST_POST = DIV_STAGES + 1;
    localparam int ST_B1   = DIV_STAGES + 2;
    localparam int ST_B2   = DIV_STAGES + 4;
    localparam int ST_OUT  = DIV_STAGES + 6;
    localparam int NSTG    = DIV_STAGES + 7;

    localparam logic signed [VW-1:0] ONE_FX =
        {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] ZERO_FX = '0;

    // ---------------------------------------------------------------- config
    logic [SRC_W-1:0] min_height_reg;
    logic [SRC_W-1:0] max_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_height_reg <= '0;
            max_height_reg <= SRC_W'(WATER_BIAS);
        end else if (cfg_wr_en) begin
            case (hwfc_reg_t'(cfg_index))
                REG_MIN_HEIGHT: min_height_reg <= cfg_data;
                REG_MAX_HEIGHT: max_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stage_en;
    logic [NSTG-1:0] valid_in;

    // A stage loads when it is empty or its item leaves this cycle.
    always_comb begin
        stage_en[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign valid_in = {valid_reg[NSTG-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign s_ready = stage_en[ST_IN];
    assign m_valid = valid_reg[ST_OUT];

    // ---------------------------------------------------------------- input stage
    logic [MAG_W-1:0] num_diff;     // h - min, 17-bit two's complement
    logic [MAG_W-1:0] rng_diff;     // max - min
    logic [MAG_W-1:0] tnum_next;
    hwfc_sign_t       sign_next;

    logic [MAG_W-1:0] tnum_reg, tden_reg;
    logic [MAG_W-1:0] wnum_reg, wden_reg;
    logic [MAG_W-1:0] snum_reg, sden_reg;
    hwfc_sign_t       sign_reg;

    always_comb begin
        num_diff = {s_terrain_height[SRC_W-1], s_terrain_height}
                 - {min_height_reg[SRC_W-1], min_height_reg};
        rng_diff = {max_height_reg[SRC_W-1], max_height_reg}
                 - {min_height_reg[SRC_W-1], min_height_reg};
        tnum_next       = num_diff[MAG_W-1] ? (~num_diff + 1'b1) : num_diff;
        sign_next.t_ok  = !rng_diff[MAG_W-1] && (rng_diff != '0);
        sign_next.t_neg = num_diff[MAG_W-1];
        sign_next.w_neg = s_water_depth[SRC_W-1];
        sign_next.s_neg = s_sediment_depth[SRC_W-1];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_IN]) begin
            tnum_reg <= tnum_next;
            tden_reg <= rng_diff;
            wnum_reg <= depth_mag(s_water_depth);
            wden_reg <= depth_mag(s_water_depth) + MAG_W'(WATER_BIAS);
            snum_reg <= depth_mag(s_sediment_depth);
            sden_reg <= depth_mag(s_sediment_depth) + MAG_W'(WATER_BIAS);
            sign_reg <= sign_next;
        end
    end

    // ---------------------------------------------------------------- dividers
    logic [QW-1:0] t_quo, w_quo, s_quo;

    // Zero range gives a junk quotient; t_ok forces t to zero after the divider.
    hwfc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .aclk     (aclk),
        .stage_en (stage_en[ST_DIV0 +: DIV_STAGES]),
        .num_mag  (tnum_reg),
        .den      (tden_reg),
        .quo      (t_quo)
    );

    hwfc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_w (
        .aclk     (aclk),
        .stage_en (stage_en[ST_DIV0 +: DIV_STAGES]),
        .num_mag  (wnum_reg),
        .den      (wden_reg),
        .quo      (w_quo)
    );

    hwfc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .aclk     (aclk),
        .stage_en (stage_en[ST_DIV0 +: DIV_STAGES]),
        .num_mag  (snum_reg),
        .den      (sden_reg),
        .quo      (s_quo)
    );

    hwfc_sign_t sign_pipe_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_sign
        if (s == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (stage_en[ST_DIV0]) begin
                    sign_pipe_reg[0] <= sign_reg;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (stage_en[ST_DIV0+s]) begin
                    sign_pipe_reg[s] <= sign_pipe_reg[s-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------- sign fix-up
    hwfc_sign_t           sign_div;
    logic signed [VW-1:0] t_mag;
    logic signed [VW-1:0] t_next;
    logic signed [WW-1:0] w_mag, s_mag;
    logic signed [WW-1:0] ww_next, sw_next;

    logic signed [VW-1:0] t_reg;
    logic signed [WW-1:0] ww_reg;
    logic signed [WW-1:0] sw_reg;

    always_comb begin
        sign_div = sign_pipe_reg[DIV_STAGES-1];
        t_mag    = VW'(t_quo);
        w_mag    = {1'b0, w_quo[FRAC_BITS-1:0]};   // weight stays below 1.0
        s_mag    = {1'b0, s_quo[FRAC_BITS-1:0]};
        if (!sign_div.t_ok) begin
            t_next = '0;
        end else begin
            t_next = sign_div.t_neg ? -t_mag : t_mag;
        end
        ww_next = sign_div.w_neg ? -w_mag : w_mag;
        sw_next = sign_div.s_neg ? -s_mag : s_mag;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_POST]) begin
            t_reg  <= t_next;
            ww_reg <= ww_next;
            sw_reg <= sw_next;
        end
    end

    // ---------------------------------------------------------------- blend toward blue
    logic signed [VW-1:0] r1, b1;
    logic signed [WW-1:0] sw_b1_reg [2];

    // Red and green share the first blend (both head toward zero).
    hwfc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_r1 (
        .aclk     (aclk),
        .stage_en (stage_en[ST_B1 +: 2]),
        .a        (t_reg),
        .target   (ZERO_FX),
        .w        (ww_reg),
        .y        (r1)
    );

    hwfc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_b1 (
        .aclk     (aclk),
        .stage_en (stage_en[ST_B1 +: 2]),
        .a        (t_reg),
        .target   (ONE_FX),
        .w        (ww_reg),
        .y        (b1)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[ST_B1]) begin
            sw_b1_reg[0] <= sw_reg;
        end
        if (stage_en[ST_B1+1]) begin
            sw_b1_reg[1] <= sw_b1_reg[0];
        end
    end

    // ---------------------------------------------------------------- blend toward cyan
    logic signed [VW-1:0] r2, g2, b2;

    hwfc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_r2 (
        .aclk     (aclk),
        .stage_en (stage_en[ST_B2 +: 2]),
        .a        (r1),
        .target   (ZERO_FX),
        .w        (sw_b1_reg[1]),
        .y        (r2)
    );

    hwfc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_g2 (
        .aclk     (aclk),
        .stage_en (stage_en[ST_B2 +: 2]),
        .a        (r1),
        .target   (ONE_FX),
        .w        (sw_b1_reg[1]),
        .y        (g2)
    );

    hwfc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_b2 (
        .aclk     (aclk),
        .stage_en (stage_en[ST_B2 +: 2]),
        .a        (b1),
        .target   (ONE_FX),
        .w        (sw_b1_reg[1]),
        .y        (b2)
    );

    // ---------------------------------------------------------------- byte pack
    // clamp(c, 0, 1) * 255, floored; 255c is (c << 8) - c.
    function automatic logic [7:0] to_byte(input logic signed [VW-1:0] c);
        logic [FRAC_BITS:0]   cl;
        logic [FRAC_BITS+8:0] prod;
        if (c[VW-1]) begin
            cl = '0;
        end else if (c > ONE_FX) begin
            cl = ONE_FX[FRAC_BITS:0];
        end else begin
            cl = c[FRAC_BITS:0];
        end
        prod = {cl, 8'b0} - (FRAC_BITS+9)'(cl);
        return prod[FRAC_BITS+7:FRAC_BITS];
    endfunction

    logic [31:0] rgba_next;
    logic [31:0] rgba_reg;

    assign rgba_next = {to_byte(r2), to_byte(g2), to_byte(b2), ALPHA};

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            rgba_reg <= rgba_next;
        end
    end

    assign m_rgba_word = rgba_reg;

    // ---------------------------------------------------------------- checks
    // Input is held off only when every stage is occupied.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("s_ready low with a free stage");

    // Items are conserved: occupancy moves only by accepted and delivered items.
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(valid_reg) == $past($countones(valid_reg))
                + $past(s_valid && s_ready) - $past(m_valid && m_ready)))
        else $error("item lost or duplicated in pipeline");

    // An accepted item lands in the input stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[ST_IN])
        else $error("accepted item not captured");

endmodule

// File: sv/hwfc_div_pipe.sv
// Pipelined restoring divider: ({num_mag, FRAC_BITS zeros}) / den, unsigned.
// Uses hwfc_pkg; stage loads come from the owner's flow control.
module hwfc_div_pipe
    import hwfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                                           aclk,
    input  logic [(FRAC_BITS+MAG_W+DIV_STEPS-1)/DIV_STEPS-1:0] stage_en,
    input  logic [MAG_W-1:0]                               num_mag,
    input  logic [MAG_W-1:0]                               den,
    output logic [FRAC_BITS+MAG_W-1:0]                     quo
);

    localparam int QW         = FRAC_BITS + MAG_W;
    localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DW         = DIV_STAGES * DIV_STEPS;

    logic [MAG_W-1:0] rem_reg [DIV_STAGES];
    logic [DW-1:0]    acc_reg [DIV_STAGES];
    logic [MAG_W-1:0] den_reg [DIV_STAGES];

    logic [DW-1:0] dvd_in;
    assign dvd_in = DW'({num_mag, {FRAC_BITS{1'b0}}});

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [MAG_W-1:0] rem_src;
        logic [DW-1:0]    acc_src;
        logic [MAG_W-1:0] den_src;
        logic [MAG_W-1:0] rem_next;
        logic [DW-1:0]    acc_next;
        logic [MAG_W:0]   trial;

        if (s == 0) begin : g_first
            assign rem_src = '0;
            assign acc_src = dvd_in;
            assign den_src = den;
        end else begin : g_rest
            assign rem_src = rem_reg[s-1];
            assign acc_src = acc_reg[s-1];
            assign den_src = den_reg[s-1];
        end

        // Shift one dividend bit into the remainder, one quotient bit into the word.
        always_comb begin
            rem_next = rem_src;
            acc_next = acc_src;
            trial    = '0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial    = {rem_next, acc_next[DW-1]};
                acc_next = {acc_next[DW-2:0], 1'b0};
                if (trial >= {1'b0, den_src}) begin
                    trial       = trial - {1'b0, den_src};
                    acc_next[0] = 1'b1;
                end
                rem_next = trial[MAG_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                rem_reg[s] <= rem_next;
                acc_reg[s] <= acc_next;
                den_reg[s] <= den_src;
            end
        end
    end

    assign quo = acc_reg[DIV_STAGES-1][QW-1:0];

endmodule

// File: sv/hwfc_blend.sv
// Two-stage blend y = a + ((target - a) * w >> FRAC_BITS), magnitude truncated.
// Uses hwfc_pkg; product split into high and low partial products.
module hwfc_blend
    import hwfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic [1:0]                  stage_en,
    input  logic signed [FRAC_BITS+21:0] a,
    input  logic signed [FRAC_BITS+21:0] target,
    input  logic signed [FRAC_BITS:0]    w,
    output logic signed [FRAC_BITS+21:0] y
);

    localparam int VW = FRAC_BITS + 22;
    localparam int HW = VW - 1 - FRAC_BITS;

    logic signed [VW-1:0]   diff;
    logic [VW-1:0]          diff_mag;
    logic [FRAC_BITS:0]     w_abs;
    logic [HW+FRAC_BITS-1:0]    phi_next;
    logic [2*FRAC_BITS-1:0]     plo_next;

    logic [HW+FRAC_BITS-1:0]    phi_reg;
    logic [2*FRAC_BITS-1:0]     plo_reg;
    logic                       neg_reg;
    logic signed [VW-1:0]       a_reg;
    logic [VW-1:0]              p_sum;
    logic signed [VW-1:0]       y_next;
    logic signed [VW-1:0]       y_reg;

    always_comb begin
        diff     = target - a;
        diff_mag = diff[VW-1] ? (~diff + 1'b1) : diff;
        w_abs    = w[FRAC_BITS] ? (~w + 1'b1) : w;
        phi_next = diff_mag[VW-2:FRAC_BITS] * w_abs[FRAC_BITS-1:0];
        plo_next = diff_mag[FRAC_BITS-1:0] * w_abs[FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            phi_reg <= phi_next;
            plo_reg <= plo_next;
            neg_reg <= diff[VW-1] ^ w[FRAC_BITS];
            a_reg   <= a;
        end
    end

    always_comb begin
        p_sum  = VW'(phi_reg) + VW'(plo_reg[2*FRAC_BITS-1:FRAC_BITS]);
        y_next = neg_reg ? (a_reg - signed'(p_sum)) : (a_reg + signed'(p_sum));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: dv/tb_top.sv
// Self-checking bench for heightmap_water_false_color: drives map cells, predicts each RGBA word.
// Depends on hwfc_pkg (register enum, WATER_BIAS, ALPHA) and the block's top level.
`timescale 1ns / 100ps

module tb_top;
    import hwfc_pkg::*;

    localparam int LONG_HOLD = 120;   // receiver hold-off, far longer than the pipe depth
    localparam int TAIL      = 24;    // drain margin after the last expected word

    // Directed cells {terrain, water, sediment}, checked under the reset bounds 0..1.0.
    localparam logic [47:0] DIRECTED_CELLS [19] = '{
        {16'h0000, 16'h0000, 16'h0000},   // black, no blending
        {16'h0100, 16'h0000, 16'h0000},   // height at max: full grey
        {16'h0080, 16'h0000, 16'h0000},   // mid grey
        {16'h7FFF, 16'h0000, 16'h0000},   // far above range, clamps high
        {16'h8000, 16'h0000, 16'h0000},   // far below range, clamps low
        {16'h0080, 16'h0100, 16'h0000},   // one unit of water
        {16'h0080, 16'h7FFF, 16'h0000},   // deepest water, weight near one
        {16'h0080, 16'h8000, 16'h0000},   // most negative water
        {16'h0080, 16'hFF00, 16'h0000},   // negative water extrapolates away from blue
        {16'h0080, 16'h0000, 16'h0100},   // one unit of sediment
        {16'h0080, 16'h0000, 16'h7FFF},   // heavy sediment
        {16'h0080, 16'h0000, 16'h8000},   // most negative sediment
        {16'h0080, 16'h0000, 16'hFF9C},   // small negative sediment
        {16'h7FFF, 16'h7FFF, 16'h7FFF},
        {16'h8000, 16'h8000, 16'h8000},
        {16'h7FFF, 16'h8000, 16'h7FFF},
        {16'h00C8, 16'h0064, 16'h0032},
        {16'hFFFF, 16'hFFFF, 16'hFFFF},   // smallest negative steps
        {16'h0001, 16'h0001, 16'h0001}    // smallest positive steps
    };

    // Predicts the RGBA word of each accepted cell and checks the words in order.
    class rgba_tracker;
        localparam int     FRAC = 16;
        localparam longint UNIT = 64'sd1 <<< FRAC;

        logic [15:0] lo_bound;
        logic [15:0] hi_bound;
        bit   [31:0] pending_rgba[$];
        int          mismatches;
        int          cells_seen;
        int          words_checked;

        function new();
            lo_bound      = 16'h0000;
            hi_bound      = 16'h0100;
            mismatches    = 0;
            cells_seen    = 0;
            words_checked = 0;
        endfunction

        function void set_bound(hwfc_reg_t idx, logic [15:0] value);
            if (idx == REG_MIN_HEIGHT)
                lo_bound = value;
            else
                hi_bound = value;
        endfunction

        // 3d / (1 + 3|d|) in FRAC bits, truncated toward zero
        static function longint depth_weight(logic [15:0] d);
            longint x3;
            longint m;
            longint q;
            x3 = 3 * longint'($signed(d));
            m  = (x3 < 0) ? -x3 : x3;
            q  = (m <<< FRAC) / (WATER_BIAS + m);
            return (x3 < 0) ? -q : q;
        endfunction

        // a + (target - a) * w, product magnitude truncated before the sign goes back on
        static function longint pull(longint a, longint target, longint w);
            longint diff;
            longint p;
            diff = target - a;
            p    = (((diff < 0) ? -diff : diff) * ((w < 0) ? -w : w)) >>> FRAC;
            return ((diff < 0) != (w < 0)) ? a - p : a + p;
        endfunction

        static function bit [7:0] channel_byte(longint c);
            if (c < 0)
                c = 0;
            if (c > UNIT)
                c = UNIT;
            return 8'((c * 255) >>> FRAC);
        endfunction

        function void note_cell(logic [15:0] h, logic [15:0] w, logic [15:0] sd);
            longint lo;
            longint hi;
            longint num;
            longint t;
            longint ww;
            longint sw;
            longint r;
            longint g;
            longint b;
            lo = longint'($signed(lo_bound));
            hi = longint'($signed(hi_bound));
            t  = 0;
            // empty or inverted range leaves the height at zero; no clamp on t
            if (hi > lo) begin
                num = longint'($signed(h)) - lo;
                t   = (((num < 0) ? -num : num) <<< FRAC) / (hi - lo);
                if (num < 0)
                    t = -t;
            end
            ww = depth_weight(w);
            sw = depth_weight(sd);
            // toward blue, then toward cyan
            r = pull(pull(t, 0, ww), 0, sw);
            g = pull(pull(t, 0, ww), UNIT, sw);
            b = pull(pull(t, UNIT, ww), UNIT, sw);
            pending_rgba.insert(pending_rgba.size(),
                                {channel_byte(r), channel_byte(g), channel_byte(b), ALPHA});
            cells_seen++;
        endfunction

        function void check_pixel(bit [31:0] got);
            bit [31:0] want;
            if (pending_rgba.size() == 0) begin
                $error("rgba_word: unexpected word, actual %08h", got);
                mismatches++;
                return;
            end
            want = pending_rgba.pop_front();
            words_checked++;
            if (got !== want) begin
                $error("rgba_word: expected %08h, actual %08h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_terrain_height;
    logic [15:0] s_water_depth;
    logic [15:0] s_sediment_depth;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_rgba_word;

    rgba_tracker tracker;
    bit          steady_flow;     // no idling on either side while set
    int          holds_asked;     // bumped by the stimulus, served by the result sink
    int          holds_done;
    int          bound_settings;

    heightmap_water_false_color u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_terrain_height (s_terrain_height),
        .s_water_depth    (s_water_depth),
        .s_sediment_depth (s_sediment_depth),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rgba_word      (m_rgba_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random Q8.8 value: full range, small magnitudes where weights move, or an extreme.
    function automatic logic [15:0] rand_q88();
        case ($urandom_range(7))
            0, 1, 2: return 16'($urandom);
            3, 4, 5: return 16'($urandom_range(1536) - 768);
            6:       return 16'($urandom_range(64) - 32);
            default: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    // Offer one cell and hold it until the block takes it. Entered right after an edge.
    task automatic offer_cell(input logic [15:0] h, input logic [15:0] w,
                              input logic [15:0] sd);
        while (!steady_flow && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_terrain_height <= h;
        s_water_depth    <= w;
        s_sediment_depth <= sd;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.note_cell(h, w, sd);
    endtask

    // Every item yields a word, so an empty queue means the pipe is empty too.
    task automatic drain();
        while (tracker.pending_rgba.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Both registers, back to back; the enable stays high across the two writes.
    task automatic set_bounds(input logic [15:0] lo, input logic [15:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MIN_HEIGHT;
        cfg_data  <= lo;
        @(posedge aclk);
        tracker.set_bound(REG_MIN_HEIGHT, lo);
        cfg_index <= REG_MAX_HEIGHT;
        cfg_data  <= hi;
        @(posedge aclk);
        tracker.set_bound(REG_MAX_HEIGHT, hi);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        bound_settings++;
    endtask

    // One bound setting followed by random cells; heights mostly near the range.
    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi, input int n,
                             input bit steady, input bit squeeze);
        longint lo_s;
        longint span;
        logic [15:0] h;
        drain();
        set_bounds(lo, hi);
        steady_flow = steady;
        lo_s = longint'($signed(lo));
        span = longint'($signed(hi)) - lo_s;
        span = ((span < 0) ? -span : span) + 64;
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == 40)
                holds_asked++;
            if ($urandom_range(3) == 0)
                h = rand_q88();
            else
                h = 16'(lo_s - 32 + longint'($urandom_range(32'(span))));
            offer_cell(h, rand_q88(), rand_q88());
        end
        s_valid     <= 1'b0;
        steady_flow = 1'b0;
    endtask

    // Result sink: checks words, idles at random, serves the long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_pixel(m_rgba_word);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_asked > holds_done) begin
                // the sender keeps offering, so the pipe fills and s_ready must drop
                holds_done++;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_flow || ($urandom_range(99) >= 23);
            end
        end
    end

    initial begin : stimulus
        tracker          = new();
        steady_flow      = 1'b0;
        holds_asked      = 0;
        holds_done       = 0;
        bound_settings   = 0;
        aresetn          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_MIN_HEIGHT;
        cfg_data         <= 16'h0000;
        s_valid          <= 1'b0;
        s_terrain_height <= 16'h0000;
        s_water_depth    <= 16'h0000;
        s_sediment_depth <= 16'h0000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed cells under the reset bounds
        foreach (DIRECTED_CELLS[i])
            offer_cell(DIRECTED_CELLS[i][47:32], DIRECTED_CELLS[i][31:16],
                       DIRECTED_CELLS[i][15:0]);
        s_valid <= 1'b0;

        run_phase(16'h8000, 16'h7FFF, 150, 1'b0, 1'b1);  // widest range, long hold-off
        run_phase(16'h7FFF, 16'h8000, 120, 1'b0, 1'b0);  // inverted range
        run_phase(16'h0200, 16'h0200, 120, 1'b0, 1'b0);  // empty range
        run_phase(16'h0000, 16'h0001, 150, 1'b0, 1'b0);  // one-step range, huge ratios
        run_phase(16'hFF00, 16'h0100, 200, 1'b1, 1'b0);  // steady stream, no idling
        for (int p = 0; p < 4; p++)
            run_phase(rand_q88(), rand_q88(), 115, 1'b0, 1'b0);
        run_phase(16'h0000, 16'h0100, 0, 1'b0, 1'b0);     // back to the reset bounds

        drain();
        repeat (TAIL) @(posedge aclk);

        $display("summary: %0d cells under %0d bound settings plus reset, %0d words compared",
                 tracker.cells_seen, bound_settings, tracker.words_checked);
        $display("summary: %0d receiver hold-off(s) of %0d cycles with the sender still offering",
                 holds_done, LONG_HOLD);
        if (tracker.pending_rgba.size() != 0)
            $error("rgba_word: %0d expected words never arrived", tracker.pending_rgba.size());
        if (tracker.mismatches == 0 && tracker.pending_rgba.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: a correct run ends well inside this.
    initial begin : watchdog
        #2_000_000;
        $display("timeout: %0d of the expected words still missing", tracker.pending_rgba.size());
        $display("status: fail");
        $finish;
    end

endmodule
